[rtl/core/lts_pkg.sv]
`timescale 1ns / 1ps
package lts_pkg;

   // Default sizes of the block.
   localparam int NUM_TOPICS_DEF = 64;
   localparam int VOCAB_SIZE_DEF = 4096;

   // Fixed field widths.
   localparam int WEIGHT_W    = 24;
   localparam int COUNT_W     = 16;
   localparam int ALPHA_W     = 16;
   localparam int FRAC_W      = 16;
   localparam int TOPIC_IDX_W = 10;
   localparam int CA_W        = COUNT_W + 8 + 1;
   localparam int PROD_W      = CA_W + WEIGHT_W;

   // Request codes.
   localparam logic [1:0] REQ_LOAD_WEIGHT = 2'd0;
   localparam logic [1:0] REQ_SET_COUNT   = 2'd1;
   localparam logic [1:0] REQ_SAMPLE      = 2'd2;

   // Result kinds.
   localparam logic KIND_LOAD   = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd128;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [11:0] word_id;
      logic [5:0]  topic_index;
      logic [23:0] load_value;
      logic [15:0] rand_fraction;
   } lts_request_type;

   typedef struct packed {
      logic [5:0] new_topic;
      logic       item_kind;
   } lts_response_type;

   // Control broadcast to every cell of the count row.
   typedef struct packed {
      logic                   ring_shift;
      logic                   prefix_shift;
      logic                   dec_en;
      logic                   inc_en;
      logic                   set_en;
      logic [TOPIC_IDX_W-1:0] target;
      logic [COUNT_W-1:0]     set_count;
   } lts_cell_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DEC,
      ST_ACC,
      ST_THR_MUL,
      ST_THR_ADD,
      ST_SCAN,
      ST_INC
   } lts_state_type;

endpackage

[rtl/core/lts_cell.sv]
`timescale 1ns / 1ps
module lts_cell #(
   parameter int CELL_IDX = 0,
   parameter int SUM_W    = 55
) (
   input  logic                       clock,
   input  logic                       reset,
   input  lts_pkg::lts_cell_ctrl_type ctrl,
   input  logic [15:0]                count_from_next,
   input  logic [SUM_W-1:0]           prefix_from_next,
   output logic [15:0]                count_out,
   output logic [SUM_W-1:0]           prefix_out
);
   import lts_pkg::*;

   logic               hit;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic [SUM_W-1:0]   prefix_ff;
   logic [SUM_W-1:0]   prefix_in;

   assign hit = (ctrl.target == TOPIC_IDX_W'(CELL_IDX));

   // Count update: rotate with the ring, or a targeted write, decrement or increment.
   always_comb begin
      count_in = count_ff;
      if (ctrl.ring_shift) begin
         count_in = count_from_next;
      end else if (hit && ctrl.set_en) begin
         count_in = ctrl.set_count;
      end else if (hit && ctrl.dec_en && (count_ff != '0)) begin
         count_in = count_ff - COUNT_W'(1);
      end else if (hit && ctrl.inc_en && (count_ff != '1)) begin
         count_in = count_ff + COUNT_W'(1);
      end
   end

   // Prefix sums move one cell toward the head on each shift.
   assign prefix_in = ctrl.prefix_shift ? prefix_from_next : prefix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      prefix_ff <= prefix_in;
   end

   assign count_out  = count_ff;
   assign prefix_out = prefix_ff;

endmodule

[rtl/core/lts_weight_mem.sv]
`timescale 1ns / 1ps
module lts_weight_mem #(
   parameter int ADDR_W = 18
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [23:0]       wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [23:0]       rd_data
);
   import lts_pkg::*;

   localparam int DEPTH = 1 << ADDR_W;

   logic [WEIGHT_W-1:0] mem [DEPTH];
   logic [WEIGHT_W-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/lda_token_topic_sampler.sv]
`timescale 1ns / 1ps
// Gibbs token sampler for a topic model.
// Input items arrive on req_data and are taken at a clock edge where start is high and
// busy is low. A weight load writes one entry of the topic-word table, a count item sets
// one document-topic count, and a sample item draws a new topic for one token.
// Every item gives exactly one result on rsp_data, marked by rsp_valid for one cycle;
// the receiver cannot stall it.
// Load and count items leave busy low and their result appears in the next cycle, so
// they can be issued back to back.
// A sample item runs one pass over NUM_TOPICS cells that forms the prefix sums (one
// weight read per cycle from the single table read port), scales the threshold with a
// multiply and then an add, and scans the cell row over up to NUM_TOPICS cells. After a
// sample item is taken, busy stays high until the draw is done, and the result appears
// in the first cycle in which busy is low again.
// Reset clears all document-topic counts and sets alpha to 0.5; the weight table keeps
// its contents. alpha is written through csr_we / csr_wdata; the user must write it only
// while the block is idle, which the block itself does not enforce.
module lda_token_topic_sampler #(
   parameter int NUM_TOPICS = lts_pkg::NUM_TOPICS_DEF,
   parameter int VOCAB_SIZE = lts_pkg::VOCAB_SIZE_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  lts_pkg::lts_request_type  req_data,
   output logic                      rsp_valid,
   output lts_pkg::lts_response_type rsp_data,
   input  logic                      csr_we,
   input  logic [15:0]               csr_wdata
);
   import lts_pkg::*;

   localparam int TOPIC_W = (NUM_TOPICS > 1) ? $clog2(NUM_TOPICS) : 1;
   localparam int WORD_AW = (VOCAB_SIZE > 1) ? $clog2(VOCAB_SIZE) : 1;
   localparam int ADDR_W  = WORD_AW + TOPIC_W;
   localparam int SUM_W   = PROD_W + TOPIC_W;
   localparam logic [TOPIC_W-1:0] LAST_TOPIC = TOPIC_W'(NUM_TOPICS - 1);

   lts_state_type      state_ff;
   lts_state_type      state_in;
   lts_cell_ctrl_type  ctrl;
   logic               accept;
   logic               in_topic_ok;
   logic               in_word_ok;
   logic [31:0]        in_word_wide;
   logic [31:0]        in_topic_wide;

   logic [ALPHA_W-1:0] alpha_ff;
   logic [WORD_AW-1:0] word_ff;
   logic               word_ok_ff;
   logic [5:0]         topic_ff;
   logic               topic_ok_ff;
   logic [FRAC_W-1:0]  frac_ff;

   logic               issuing_ff;
   logic [TOPIC_W-1:0] issue_k_ff;
   logic               rd_v_ff;
   logic [WEIGHT_W-1:0] rd_data;
   logic [WEIGHT_W-1:0] w_eff;
   logic [CA_W-1:0]    ca;
   logic [PROD_W-1:0]  prod_ff;
   logic               prod_v_ff;
   logic [TOPIC_W-1:0] push_k_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic [SUM_W-1:0]   push_sum;
   logic [SUM_W-17:0]  prod_hi_ff;
   logic [47:0]        prod_lo_ff;
   logic [SUM_W-1:0]   thr_ff;
   logic [TOPIC_W-1:0] scan_k_ff;
   logic [TOPIC_W-1:0] found_k_ff;
   logic               scan_hit;

   logic               rsp_valid_ff;
   lts_response_type   rsp_ff;

   logic [COUNT_W-1:0] count_chain  [NUM_TOPICS];
   logic [SUM_W-1:0]   prefix_chain [NUM_TOPICS];

   assign accept        = start && (state_ff == ST_IDLE);
   assign busy          = (state_ff != ST_IDLE);
   assign in_word_wide  = 32'(req_data.word_id);
   assign in_topic_wide = 32'(req_data.topic_index);
   assign in_word_ok    = (in_word_wide < 32'(VOCAB_SIZE));
   assign in_topic_ok   = (in_topic_wide < 32'(NUM_TOPICS));

   // Weight table.
   lts_weight_mem #(
      .ADDR_W(ADDR_W)
   ) u_weight_mem (
      .clock  (clock),
      .wr_en  (accept && (req_data.req_type == REQ_LOAD_WEIGHT) && in_word_ok && in_topic_ok),
      .wr_addr({in_word_wide[WORD_AW-1:0], in_topic_wide[TOPIC_W-1:0]}),
      .wr_data(req_data.load_value),
      .rd_en  (issuing_ff),
      .rd_addr({word_ff, issue_k_ff}),
      .rd_data(rd_data)
   );

   // Row of count cells; counts rotate as a ring, prefix sums enter at the tail.
   for (genvar i = 0; i < NUM_TOPICS; i++) begin : g_cell
      logic [COUNT_W-1:0] count_next;
      logic [SUM_W-1:0]   prefix_next;
      if (i == NUM_TOPICS - 1) begin : g_tail
         assign count_next  = count_chain[0];
         assign prefix_next = push_sum;
      end else begin : g_mid
         assign count_next  = count_chain[i+1];
         assign prefix_next = prefix_chain[i+1];
      end
      lts_cell #(
         .CELL_IDX(i),
         .SUM_W   (SUM_W)
      ) u_cell (
         .clock           (clock),
         .reset           (reset),
         .ctrl            (ctrl),
         .count_from_next (count_next),
         .prefix_from_next(prefix_next),
         .count_out       (count_chain[i]),
         .prefix_out      (prefix_chain[i])
      );
   end

   // Term datapath at the head of the row.
   assign w_eff    = word_ok_ff ? rd_data : '0;
   assign ca       = {1'b0, count_chain[0], 8'b0} + CA_W'(alpha_ff);
   assign push_sum = sum_ff + SUM_W'(prod_ff);
   assign scan_hit = (prefix_chain[0] >= thr_ff) || (scan_k_ff == LAST_TOPIC);

   // Next state and cell control.
   always_comb begin
      state_in          = state_ff;
      ctrl              = '0;
      ctrl.set_count    = req_data.load_value[COUNT_W-1:0];
      ctrl.target       = TOPIC_IDX_W'(req_data.topic_index);
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ctrl.set_en = (req_data.req_type == REQ_SET_COUNT) && in_topic_ok;
               if (req_data.req_type == REQ_SAMPLE) begin
                  state_in = ST_DEC;
               end
            end
         end
         ST_DEC: begin
            ctrl.target = TOPIC_IDX_W'(topic_ff);
            ctrl.dec_en = topic_ok_ff;
            state_in    = ST_ACC;
         end
         ST_ACC: begin
            ctrl.ring_shift   = rd_v_ff;
            ctrl.prefix_shift = prod_v_ff;
            if (prod_v_ff && (push_k_ff == LAST_TOPIC)) begin
               state_in = ST_THR_MUL;
            end
         end
         ST_THR_MUL: begin
            state_in = ST_THR_ADD;
         end
         ST_THR_ADD: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_hit) begin
               state_in = ST_INC;
            end else begin
               ctrl.prefix_shift = 1'b1;
            end
         end
         ST_INC: begin
            ctrl.target = TOPIC_IDX_W'(found_k_ff);
            ctrl.inc_en = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= ALPHA_RESET;
      end else if (csr_we) begin
         alpha_ff <= csr_wdata;
      end
   end

   // Pipeline control for the accumulation pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         issuing_ff <= 1'b0;
         rd_v_ff    <= 1'b0;
         prod_v_ff  <= 1'b0;
      end else begin
         rd_v_ff   <= issuing_ff;
         prod_v_ff <= rd_v_ff;
         if (state_ff == ST_DEC) begin
            issuing_ff <= 1'b1;
         end else if (issuing_ff && (issue_k_ff == LAST_TOPIC)) begin
            issuing_ff <= 1'b0;
         end
      end
   end

   // Sample datapath.
   always_ff @(posedge clock) begin
      if (accept) begin
         word_ff     <= in_word_wide[WORD_AW-1:0];
         word_ok_ff  <= in_word_ok;
         topic_ff    <= req_data.topic_index;
         topic_ok_ff <= in_topic_ok;
         frac_ff     <= req_data.rand_fraction;
      end
      if (state_ff == ST_DEC) begin
         issue_k_ff <= '0;
         push_k_ff  <= '0;
         sum_ff     <= '0;
      end else begin
         if (issuing_ff) begin
            issue_k_ff <= issue_k_ff + TOPIC_W'(1);
         end
         if (prod_v_ff) begin
            sum_ff    <= push_sum;
            push_k_ff <= push_k_ff + TOPIC_W'(1);
         end
      end
      if (rd_v_ff) begin
         prod_ff <= PROD_W'(ca) * PROD_W'(w_eff);
      end
      // Threshold = floor(total * fraction / 2^16), in two halves.
      if (state_ff == ST_THR_MUL) begin
         prod_hi_ff <= (SUM_W-16)'(sum_ff[SUM_W-1:32]) * (SUM_W-16)'(frac_ff);
         prod_lo_ff <= 48'(sum_ff[31:0]) * 48'(frac_ff);
      end
      if (state_ff == ST_THR_ADD) begin
         thr_ff    <= {prod_hi_ff, 16'b0} + SUM_W'(prod_lo_ff[47:16]);
         scan_k_ff <= '0;
      end
      if (state_ff == ST_SCAN) begin
         if (scan_hit) begin
            found_k_ff <= scan_k_ff;
         end else begin
            scan_k_ff <= scan_k_ff + TOPIC_W'(1);
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (accept && (req_data.req_type != REQ_SAMPLE)) || (state_ff == ST_INC);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_INC) begin
         rsp_ff.new_topic <= 6'(found_k_ff);
         rsp_ff.item_kind <= KIND_SAMPLE;
      end else begin
         rsp_ff.new_topic <= '0;
         rsp_ff.item_kind <= KIND_LOAD;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // An accepted sample item makes the block busy on the next cycle.
   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.req_type == REQ_SAMPLE)) |=> busy)
      else $error("sample item did not start the sampler");

   // A sample result follows the increment step and nothing else.
   a_sample_src: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.item_kind == KIND_SAMPLE)) |-> $past(state_ff == ST_INC))
      else $error("sample result without a finished draw");

   // Load acknowledgements carry topic zero.
   a_load_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.item_kind == KIND_LOAD)) |-> (rsp_data.new_topic == '0))
      else $error("load acknowledgement with nonzero topic");

   // The scan leaves after the last topic at the latest.
   a_scan_end: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN) && (scan_k_ff == LAST_TOPIC)) |=> (state_ff == ST_INC))
      else $error("scan ran past the last topic");
`endif

endmodule

[test/lda_token_topic_sampler_tb.sv]
`timescale 1ns / 1ps
module lda_token_topic_sampler_tb;
   import lts_pkg::*;

   localparam int TOPICS = 64;
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   lts_request_type  req_data;
   logic             rsp_valid;
   lts_response_type rsp_data;
   logic             csr_we;
   logic [15:0]      csr_wdata;

   // Mirror of the block state used to predict each drawn topic.
   logic [15:0] model_alpha;
   logic [15:0] model_count [TOPICS];
   logic [23:0] model_weight [int];
   int          ready_words [$];
   int          loaded_entries [int];

   lts_response_type drawn_topics_due [$];
   int  mismatch_count;
   bit  idle_enabled;

   // One directed row, with a typed-in result where it is obvious.
   typedef struct {
      lts_request_type item;
      bit              fixed;
      logic [5:0]      topic;
      logic            kind;
   } directed_row_type;

   lda_token_topic_sampler DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   // Removes the token, forms the prefix sums and draws the new topic.
   function automatic logic [5:0] draw_topic(input logic [11:0] word, input logic [5:0] old,
                                             input logic [15:0] frac);
      logic [79:0] running;
      logic [79:0] prefix [TOPICS];
      logic [79:0] threshold;
      logic [24:0] scaled_count;
      int          k;
      if (model_count[old] != 16'd0)
         model_count[old] = model_count[old] - 16'd1;
      running = '0;
      for (k = 0; k < TOPICS; k++) begin
         scaled_count = {1'b0, model_count[k], 8'd0} + 25'(model_alpha);
         running = running + 80'(scaled_count) * 80'(model_weight[word * TOPICS + k]);
         prefix[k] = running;
      end
      threshold = (running * 80'(frac)) >> 16;
      k = 0;
      while (k < TOPICS - 1 && prefix[k] < threshold)
         k++;
      if (model_count[k] != 16'hFFFF)
         model_count[k] = model_count[k] + 16'd1;
      return 6'(k);
   endfunction

   // Updates the mirror for one accepted item and returns its result.
   function automatic lts_response_type predict_result(input lts_request_type item);
      lts_response_type res;
      int               key;
      res.new_topic = '0;
      res.item_kind = KIND_LOAD;
      case (item.req_type)
         REQ_LOAD_WEIGHT: begin
            key = item.word_id * TOPICS + item.topic_index;
            if (!model_weight.exists(key)) begin
               if (!loaded_entries.exists(item.word_id))
                  loaded_entries[item.word_id] = 0;
               loaded_entries[item.word_id]++;
               if (loaded_entries[item.word_id] == TOPICS)
                  ready_words.push_back(item.word_id);
            end
            model_weight[key] = item.load_value;
         end
         REQ_SET_COUNT: model_count[item.topic_index] = item.load_value[15:0];
         REQ_SAMPLE: begin
            res.new_topic = draw_topic(item.word_id, item.topic_index, item.rand_fraction);
            res.item_kind = KIND_SAMPLE;
         end
         default: ;
      endcase
      return res;
   endfunction

   // Presents one item and holds it until the block takes it.
   task automatic send_item(input lts_request_type item, input bit fixed,
                            input lts_response_type fixed_res);
      lts_response_type res;
      start <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      res = predict_result(item);
      drawn_topics_due.push_back(fixed ? fixed_res : res);
   endtask

   task automatic maybe_idle();
      if (idle_enabled && $urandom_range(0, 5) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (drawn_topics_due.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_alpha(input logic [15:0] value);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      model_alpha = value;
   endtask

   function automatic lts_request_type make_item(input logic [1:0] kind, input int word,
                                                 input int topic, input int value,
                                                 input int frac);
      lts_request_type item;
      item.req_type = kind;
      item.word_id = 12'(word);
      item.topic_index = 6'(topic);
      item.load_value = 24'(value);
      item.rand_fraction = 16'(frac);
      return item;
   endfunction

   task automatic load_word(input int word, input int mode);
      int t;
      int value;
      for (t = 0; t < TOPICS; t++) begin
         case (mode)
            0: value = 0;
            1: value = 24'hFFFFFF;
            2: value = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 24'hFFFFFF);
            default: value = $urandom_range(0, 255);
         endcase
         send_item(make_item(REQ_LOAD_WEIGHT, word, t, value, $urandom), 1'b0, '0);
         maybe_idle();
      end
   endtask

   // Random traffic, mostly samples over fully loaded words.
   task automatic random_phase(input int count);
      int               n;
      int               pick;
      int               value;
      lts_request_type  item;
      for (n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 62) begin
            item = make_item(REQ_SAMPLE, ready_words[$urandom_range(0, ready_words.size() - 1)],
                             $urandom, $urandom, $urandom);
            if ($urandom_range(0, 9) == 0)
               item.rand_fraction = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         end else if (pick < 77) begin
            item = make_item(REQ_LOAD_WEIGHT, $urandom, $urandom, $urandom, $urandom);
         end else if (pick < 93) begin
            case ($urandom_range(0, 3))
               0: value = 24'hFF0000 | 16'hFFFF;
               1: value = $urandom_range(0, 24'hFFFFFF);
               default: value = $urandom_range(0, 40) | ($urandom & 24'hFF0000);
            endcase
            item = make_item(REQ_SET_COUNT, $urandom, $urandom, value, $urandom);
         end else begin
            item = make_item(REQ_UNUSED, $urandom, $urandom, $urandom, $urandom);
         end
         send_item(item, 1'b0, '0);
         maybe_idle();
      end
   endtask

   // Every result is checked against the oldest prediction.
   always @(posedge clock) begin
      lts_response_type due;
      if (!reset && rsp_valid) begin
         if (drawn_topics_due.size() == 0) begin
            report_mismatch("result with nothing expected");
         end else begin
            due = drawn_topics_due.pop_front();
            if (rsp_data.item_kind !== due.item_kind)
               report_mismatch($sformatf("item_kind %0d, expected %0d",
                                         rsp_data.item_kind, due.item_kind));
            if (rsp_data.new_topic !== due.new_topic)
               report_mismatch($sformatf("new_topic %0d, expected %0d",
                                         rsp_data.new_topic, due.new_topic));
         end
      end
   end

   initial begin
      #20ms;
      $display("** lda_token_topic_sampler: FAILED **");
      $finish;
   end

   initial begin
      directed_row_type rows [$];
      directed_row_type row;
      int               i;
      int               w;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      mismatch_count = 0;
      idle_enabled = 1'b1;
      model_alpha = ALPHA_RESET;
      foreach (model_count[k]) model_count[k] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Word 0 holds only zero weights, the top word only full-scale weights.
      load_word(0, 0);
      load_word(4095, 1);
      for (i = 0; i < 4; i++) begin
         do w = $urandom_range(1, 4094); while (loaded_entries.exists(w));
         load_word(w, i == 3 ? 3 : 2);
      end

      // Directed cases: all-zero weights, fraction extremes, count saturation, unused type.
      row.fixed = 1'b1; row.kind = KIND_SAMPLE; row.topic = 6'd0;
      row.item = make_item(REQ_SAMPLE, 0, 63, 0, 16'hFFFF); rows.push_back(row);
      row.item = make_item(REQ_SAMPLE, 4095, 0, 0, 0); rows.push_back(row);
      row.kind = KIND_LOAD;
      row.item = make_item(REQ_UNUSED, 4095, 63, 24'hFFFFFF, 16'hFFFF); rows.push_back(row);
      row.item = make_item(REQ_SET_COUNT, 4095, 5, 24'hFFFFFF, 0); rows.push_back(row);
      row.item = make_item(REQ_SET_COUNT, 0, 63, 24'hFF0000, 0); rows.push_back(row);
      row.item = make_item(REQ_LOAD_WEIGHT, 0, 63, 0, 0); rows.push_back(row);
      row.fixed = 1'b0;
      row.item = make_item(REQ_SAMPLE, 4095, 63, 0, 16'hFFFF); rows.push_back(row);
      row.item = make_item(REQ_SAMPLE, 4095, 5, 0, 16'h8000); rows.push_back(row);
      row.item = make_item(REQ_SAMPLE, 4095, 1, 0, 16'h0001); rows.push_back(row);
      row.item = make_item(REQ_SET_COUNT, 0, 9, 16'hFFFE, 0); rows.push_back(row);
      row.item = make_item(REQ_SAMPLE, ready_words[2], 9, 0, 16'hC000); rows.push_back(row);
      row.item = make_item(REQ_SAMPLE, ready_words[3], 9, 0, 16'h4000); rows.push_back(row);
      row.item = make_item(REQ_SAMPLE, ready_words[4], 0, 0, 16'hFFFF); rows.push_back(row);
      row.item = make_item(REQ_SAMPLE, ready_words[5], 63, 0, 16'h0000); rows.push_back(row);
      foreach (rows[r]) begin
         send_item(rows[r].item, rows[r].fixed, '{new_topic: rows[r].topic,
                                                  item_kind: rows[r].kind});
         maybe_idle();
      end

      // Phases over several alpha settings, extremes included.
      write_alpha(16'hFFFF);
      random_phase(250);
      write_alpha(16'h0000);
      random_phase(250);
      // A fresh word is loaded in the middle of the run.
      do w = $urandom_range(0, 4095); while (loaded_entries.exists(w));
      load_word(w, 2);
      write_alpha(16'($urandom));
      random_phase(250);
      drain();
      write_alpha(ALPHA_RESET);
      idle_enabled = 1'b0;
      random_phase(440);

      drain();
      repeat (300) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("** lda_token_topic_sampler: PASSED **");
      end else begin
         $display("** lda_token_topic_sampler: FAILED **");
      end
      $finish;
   end

endmodule
